/* design/ptu_pkg.sv */
// Shared types, codes and helpers for the particle table update core.
package ptu_pkg;

  localparam logic [1:0] ACT_SPAWN = 2'd0;
  localparam logic [1:0] ACT_TICK  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  localparam logic [2:0] KIND_SPAWNED  = 3'd0;
  localparam logic [2:0] KIND_DROPPED  = 3'd1;
  localparam logic [2:0] KIND_PARTICLE = 3'd2;
  localparam logic [2:0] KIND_NONE     = 3'd3;
  localparam logic [2:0] KIND_CLEARED  = 3'd4;

  localparam logic [1:0] CFG_GRAVITY_ON    = 2'd0;
  localparam logic [1:0] CFG_GRAVITY_ACCEL = 2'd1;
  localparam logic [1:0] CFG_DRAG_RATE     = 2'd2;
  localparam logic [1:0] CFG_LIMIT         = 2'd3;

  localparam logic [16:0] ONE_Q16   = 17'h10000;
  localparam logic [2:0]  LANE_LAST_AXIS  = 3'd2;
  localparam logic [2:0]  LANE_LAST_BLEND = 3'd4;
  localparam logic [4:0]  DIV_STEPS = 5'd16;

  typedef struct packed {
    logic [1:0]         action;
    logic [15:0]        dt;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic [23:0]        life;
    logic [31:0]        start_color;
    logic [31:0]        end_color;
    logic [31:0]        sizes;
  } in_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [31:0]        out_color;
    logic [15:0]        out_size;
    logic [5:0]         slot;
    logic [6:0]         live_count;
    logic               last;
  } out_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic [23:0]        life_left;
    logic [23:0]        life_total;
    logic [31:0]        color_from;
    logic [31:0]        color_to;
    logic [31:0]        size_pair;
  } rec_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_SPAWN,
    OP_READ,
    OP_LOAD,
    OP_MUL_DRAGF,
    OP_SET_DRAGF,
    OP_MUL_GRAV,
    OP_ADD_GRAV,
    OP_MUL_DRAG,
    OP_SET_DRAG,
    OP_MUL_MOVE,
    OP_ADD_MOVE,
    OP_MUL_BLEND,
    OP_SET_BLEND,
    OP_WRITE,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [2:0] lane;
    logic [5:0] addr;
    logic [2:0] kind;
    logic [6:0] count;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic dead;
    logic div_done;
  } sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [33:0] hi;
    logic signed [33:0] lo;
    hi = 34'sh07FFFFFFF;
    lo = -34'sh080000000;
    if (v > hi) begin
      sat32 = 32'sh7FFFFFFF;
    end else if (v < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

/* design/ptu_ctrl.sv */
// Controller: sequences spawn, clear, the per-particle tick steps and the emit pass.
module ptu_ctrl #(
  parameter int MAX_PARTICLES = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [1:0]    action,
  input  logic [6:0]    particle_limit,
  input  logic          out_stall,
  input  ptu_pkg::sts_t sts,
  output logic          in_stall,
  output logic          out_valid,
  output ptu_pkg::cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_SPAWN, S_SINGLE, S_DRAGF_M, S_DRAGF_A, S_RD, S_LOAD, S_CHK,
    S_GRAV_M, S_GRAV_A, S_DRAG_M, S_DRAG_A, S_MOVE_M, S_MOVE_A, S_DIV_WAIT,
    S_BLEND_M, S_BLEND_A, S_WRITE, S_DONE, S_EMIT_RD, S_EMIT_OUT
  } state_t;

  localparam logic [6:0] MAX_LIVE = 7'(MAX_PARTICLES);

  state_t     state;
  logic [6:0] live;
  logic [6:0] idx;
  logic [6:0] wr;
  logic [6:0] emit;
  logic [2:0] lane;
  logic [2:0] single_kind;
  logic       out_free;
  logic [6:0] lim;
  logic       idx_end;
  logic       emit_end;

  assign out_free = !out_valid || !out_stall;
  assign lim      = (particle_limit < MAX_LIVE) ? particle_limit : MAX_LIVE;
  assign idx_end  = (idx + 7'd1) == live;
  assign emit_end = (emit + 7'd1) == live;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd       = '0;
    cmd.op    = ptu_pkg::OP_IDLE;
    cmd.lane  = lane;
    cmd.count = live;
    unique case (state)
      S_SPAWN: begin
        if (live < lim) begin
          cmd.op   = ptu_pkg::OP_SPAWN;
          cmd.addr = live[5:0];
        end
      end
      S_SINGLE: begin
        cmd.kind = single_kind;
        cmd.last = 1'b1;
        if (out_free) begin
          cmd.op = ptu_pkg::OP_OUT;
        end
      end
      S_DRAGF_M: cmd.op = ptu_pkg::OP_MUL_DRAGF;
      S_DRAGF_A: cmd.op = ptu_pkg::OP_SET_DRAGF;
      S_RD: begin
        cmd.op   = ptu_pkg::OP_READ;
        cmd.addr = idx[5:0];
      end
      S_LOAD:    cmd.op = ptu_pkg::OP_LOAD;
      S_CHK:     cmd.op = ptu_pkg::OP_IDLE;
      S_GRAV_M:  cmd.op = ptu_pkg::OP_MUL_GRAV;
      S_GRAV_A:  cmd.op = ptu_pkg::OP_ADD_GRAV;
      S_DRAG_M:  cmd.op = ptu_pkg::OP_MUL_DRAG;
      S_DRAG_A:  cmd.op = ptu_pkg::OP_SET_DRAG;
      S_MOVE_M:  cmd.op = ptu_pkg::OP_MUL_MOVE;
      S_MOVE_A:  cmd.op = ptu_pkg::OP_ADD_MOVE;
      S_DIV_WAIT: cmd.op = ptu_pkg::OP_IDLE;
      S_BLEND_M: cmd.op = ptu_pkg::OP_MUL_BLEND;
      S_BLEND_A: cmd.op = ptu_pkg::OP_SET_BLEND;
      S_WRITE: begin
        cmd.op   = ptu_pkg::OP_WRITE;
        cmd.addr = wr[5:0];
      end
      S_EMIT_RD: begin
        cmd.op   = ptu_pkg::OP_READ;
        cmd.addr = emit[5:0];
      end
      S_EMIT_OUT: begin
        cmd.kind = ptu_pkg::KIND_PARTICLE;
        cmd.addr = emit[5:0];
        cmd.last = emit_end;
        if (out_free) begin
          cmd.op = ptu_pkg::OP_OUT;
        end
      end
      default: cmd.op = ptu_pkg::OP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      live        <= '0;
      idx         <= '0;
      wr          <= '0;
      emit        <= '0;
      lane        <= '0;
      single_kind <= ptu_pkg::KIND_SPAWNED;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.op == ptu_pkg::OP_OUT) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (action)
              ptu_pkg::ACT_SPAWN: state <= S_SPAWN;
              ptu_pkg::ACT_TICK:  state <= S_DRAGF_M;
              ptu_pkg::ACT_CLEAR: begin
                live        <= '0;
                single_kind <= ptu_pkg::KIND_CLEARED;
                state       <= S_SINGLE;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_SPAWN: begin
          if (live < lim) begin
            live        <= live + 7'd1;
            single_kind <= ptu_pkg::KIND_SPAWNED;
          end else begin
            single_kind <= ptu_pkg::KIND_DROPPED;
          end
          state <= S_SINGLE;
        end
        S_SINGLE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_DRAGF_M: state <= S_DRAGF_A;
        S_DRAGF_A: begin
          idx   <= '0;
          wr    <= '0;
          state <= (live == 7'd0) ? S_DONE : S_RD;
        end
        S_RD:   state <= S_LOAD;
        S_LOAD: state <= S_CHK;
        S_CHK: begin
          if (sts.dead) begin
            idx   <= idx + 7'd1;
            state <= idx_end ? S_DONE : S_RD;
          end else begin
            state <= S_GRAV_M;
          end
        end
        S_GRAV_M: state <= S_GRAV_A;
        S_GRAV_A: begin
          lane  <= '0;
          state <= S_DRAG_M;
        end
        S_DRAG_M: state <= S_DRAG_A;
        S_DRAG_A: begin
          if (lane == ptu_pkg::LANE_LAST_AXIS) begin
            lane  <= '0;
            state <= S_MOVE_M;
          end else begin
            lane  <= lane + 3'd1;
            state <= S_DRAG_M;
          end
        end
        S_MOVE_M: state <= S_MOVE_A;
        S_MOVE_A: begin
          if (lane == ptu_pkg::LANE_LAST_AXIS) begin
            lane  <= '0;
            state <= S_DIV_WAIT;
          end else begin
            lane  <= lane + 3'd1;
            state <= S_MOVE_M;
          end
        end
        S_DIV_WAIT: begin
          if (sts.div_done) begin
            state <= S_BLEND_M;
          end
        end
        S_BLEND_M: state <= S_BLEND_A;
        S_BLEND_A: begin
          if (lane == ptu_pkg::LANE_LAST_BLEND) begin
            lane  <= '0;
            state <= S_WRITE;
          end else begin
            lane  <= lane + 3'd1;
            state <= S_BLEND_M;
          end
        end
        S_WRITE: begin
          wr    <= wr + 7'd1;
          idx   <= idx + 7'd1;
          state <= idx_end ? S_DONE : S_RD;
        end
        S_DONE: begin
          live <= wr;
          emit <= '0;
          if (wr == 7'd0) begin
            single_kind <= ptu_pkg::KIND_NONE;
            state       <= S_SINGLE;
          end else begin
            state <= S_EMIT_RD;
          end
        end
        S_EMIT_RD: state <= S_EMIT_OUT;
        S_EMIT_OUT: begin
          if (out_free) begin
            emit  <= emit + 7'd1;
            state <= emit_end ? S_IDLE : S_EMIT_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* design/ptu_dpath.sv */
// Datapath: particle memories, shared multiplier, life divider and result register.
module ptu_dpath #(
  parameter int MAX_PARTICLES = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  ptu_pkg::in_t  in_data,
  input  logic          gravity_on,
  input  logic [23:0]   gravity_accel,
  input  logic [23:0]   drag_rate,
  input  ptu_pkg::cmd_t cmd,
  output ptu_pkg::sts_t sts,
  output ptu_pkg::out_t out_data
);

  localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam logic [24:0] ONE = 25'(ptu_pkg::ONE_Q16);

  ptu_pkg::rec_t      mem [MAX_PARTICLES];
  logic [47:0]        res_mem [MAX_PARTICLES];
  ptu_pkg::rec_t      rd;
  logic [47:0]        rd_res;
  ptu_pkg::in_t       item;
  ptu_pkg::rec_t      wr_rec;

  logic signed [31:0] pos [3];
  logic signed [31:0] vel [3];
  logic [23:0]        life_w;
  logic [16:0]        drag_f;
  logic [16:0]        t;
  logic [7:0]         col [4];
  logic [15:0]        size_w;

  logic signed [32:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [50:0] prod;
  logic signed [50:0] prod_sh;
  logic signed [50:0] prod_rnd;

  logic [15:0]        bl_a;
  logic [15:0]        bl_b;
  logic [15:0]        bl_res;

  logic [23:0]        life_new;
  logic [24:0]        rem;
  logic [24:0]        rem2;
  logic               ge;
  logic [15:0]        quo;
  logic [4:0]         dcnt;
  logic               busy;

  assign prod_sh  = prod >>> 16;
  assign prod_rnd = (prod + 51'sd32768) >>> 16;

  always_comb begin
    unique case (cmd.lane)
      3'd0: begin bl_a = {8'd0, rd.color_from[31:24]}; bl_b = {8'd0, rd.color_to[31:24]}; end
      3'd1: begin bl_a = {8'd0, rd.color_from[23:16]}; bl_b = {8'd0, rd.color_to[23:16]}; end
      3'd2: begin bl_a = {8'd0, rd.color_from[15:8]};  bl_b = {8'd0, rd.color_to[15:8]};  end
      3'd3: begin bl_a = {8'd0, rd.color_from[7:0]};   bl_b = {8'd0, rd.color_to[7:0]};   end
      default: begin bl_a = rd.size_pair[31:16]; bl_b = rd.size_pair[15:0]; end
    endcase
  end

  // a + round((b - a) * t / 2^16) equals the rounded weighted blend
  assign bl_res = 16'(18'($signed({2'b00, bl_a})) + 18'(prod_rnd[17:0]));

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      ptu_pkg::OP_MUL_DRAGF: begin
        mul_a = $signed({9'd0, drag_rate});
        mul_b = $signed({2'b00, item.dt});
      end
      ptu_pkg::OP_MUL_GRAV: begin
        mul_a = $signed({{9{gravity_accel[23]}}, gravity_accel});
        mul_b = $signed({2'b00, item.dt});
      end
      ptu_pkg::OP_MUL_DRAG: begin
        mul_a = 33'(vel[cmd.lane[1:0]]);
        mul_b = $signed({1'b0, drag_f});
      end
      ptu_pkg::OP_MUL_MOVE: begin
        mul_a = 33'(vel[cmd.lane[1:0]]);
        mul_b = $signed({2'b00, item.dt});
      end
      ptu_pkg::OP_MUL_BLEND: begin
        mul_a = 33'($signed({1'b0, bl_b}) - $signed({1'b0, bl_a}));
        mul_b = $signed({1'b0, t});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    wr_rec = rd;
    if (cmd.op == ptu_pkg::OP_SPAWN) begin
      wr_rec.px         = item.pos_x;
      wr_rec.py         = item.pos_y;
      wr_rec.pz         = item.pos_z;
      wr_rec.vx         = item.vel_x;
      wr_rec.vy         = item.vel_y;
      wr_rec.vz         = item.vel_z;
      wr_rec.life_left  = item.life;
      wr_rec.life_total = item.life;
      wr_rec.color_from = item.start_color;
      wr_rec.color_to   = item.end_color;
      wr_rec.size_pair  = item.sizes;
    end else begin
      wr_rec.px        = pos[0];
      wr_rec.py        = pos[1];
      wr_rec.pz        = pos[2];
      wr_rec.vx        = vel[0];
      wr_rec.vy        = vel[1];
      wr_rec.vz        = vel[2];
      wr_rec.life_left = life_w;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == ptu_pkg::OP_SPAWN || cmd.op == ptu_pkg::OP_WRITE) begin
      mem[cmd.addr[AW-1:0]] <= wr_rec;
    end
    if (cmd.op == ptu_pkg::OP_WRITE) begin
      res_mem[cmd.addr[AW-1:0]] <= {col[0], col[1], col[2], col[3], size_w};
    end
    if (cmd.op == ptu_pkg::OP_READ) begin
      rd     <= mem[cmd.addr[AW-1:0]];
      rd_res <= res_mem[cmd.addr[AW-1:0]];
    end
  end

  assign life_new = (rd.life_left > {8'd0, item.dt}) ? rd.life_left - {8'd0, item.dt} : '0;
  assign rem2     = {rem[23:0], 1'b0};
  assign ge       = rem2 >= {1'b0, rd.life_total};

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_data;
    end
    prod <= 51'(mul_a) * 51'(mul_b);
    case (cmd.op)
      ptu_pkg::OP_SET_DRAGF: begin
        drag_f <= (prod_sh[23:0] >= 24'(ONE)) ? '0 : 17'(ONE - 25'(prod_sh[23:0]));
      end
      ptu_pkg::OP_LOAD: begin
        pos[0] <= rd.px;
        pos[1] <= rd.py;
        pos[2] <= rd.pz;
        vel[0] <= rd.vx;
        vel[1] <= rd.vy;
        vel[2] <= rd.vz;
        life_w <= life_new;
      end
      ptu_pkg::OP_ADD_GRAV: begin
        if (gravity_on) begin
          vel[1] <= ptu_pkg::sat32(34'(vel[1]) - prod_sh[33:0]);
        end
      end
      ptu_pkg::OP_SET_DRAG: vel[cmd.lane[1:0]] <= prod_sh[31:0];
      ptu_pkg::OP_ADD_MOVE: begin
        pos[cmd.lane[1:0]] <= ptu_pkg::sat32(34'(pos[cmd.lane[1:0]]) + prod_sh[33:0]);
      end
      ptu_pkg::OP_SET_BLEND: begin
        if (cmd.lane == ptu_pkg::LANE_LAST_BLEND) begin
          size_w <= bl_res;
        end else begin
          col[cmd.lane[1:0]] <= bl_res[7:0];
        end
      end
      ptu_pkg::OP_OUT: begin
        out_data.kind       <= cmd.kind;
        out_data.live_count <= cmd.count;
        out_data.last       <= cmd.last;
        if (cmd.kind == ptu_pkg::KIND_PARTICLE) begin
          out_data.out_x     <= rd.px;
          out_data.out_y     <= rd.py;
          out_data.out_z     <= rd.pz;
          out_data.out_color <= rd_res[47:16];
          out_data.out_size  <= rd_res[15:0];
          out_data.slot      <= cmd.addr;
        end else begin
          out_data.out_x     <= '0;
          out_data.out_y     <= '0;
          out_data.out_z     <= '0;
          out_data.out_color <= '0;
          out_data.out_size  <= '0;
          out_data.slot      <= '0;
        end
      end
      default: ;
    endcase
  end

  // restoring divide: t = 1 - life/total, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      dcnt <= '0;
    end else if (cmd.op == ptu_pkg::OP_LOAD) begin
      rem  <= {1'b0, life_new};
      quo  <= '0;
      dcnt <= ptu_pkg::DIV_STEPS;
      if (rd.life_total == '0) begin
        t    <= ptu_pkg::ONE_Q16;
        busy <= 1'b0;
      end else if (life_new >= rd.life_total) begin
        t    <= '0;
        busy <= 1'b0;
      end else begin
        busy <= 1'b1;
      end
    end else if (busy) begin
      rem  <= ge ? rem2 - {1'b0, rd.life_total} : rem2;
      quo  <= {quo[14:0], ge};
      dcnt <= dcnt - 5'd1;
      if (dcnt == 5'd1) begin
        busy <= 1'b0;
        t    <= ptu_pkg::ONE_Q16 - {1'b0, quo[14:0], ge};
      end
    end
  end

  assign sts.dead     = (life_w == '0);
  assign sts.div_done = !busy;

endmodule

/* design/particle_table_update_core.sv */
// Particle table update core: top level with configuration registers.
// Keeps up to MAX_PARTICLES particles in an on-chip table. A spawn or clear
// item gives a single result. A tick reads each stored particle in turn
// through one shared 33x18 multiplier: a dead particle is skipped after its
// check, a surviving one passes the gravity, drag and move steps (each a
// multiply and then an add or set, with a life divider running beside them)
// and 5 blend steps, and the emit pass then reads and sends each survivor.
// Results of a tick carry the final live count, so they leave only after the
// whole table has been walked. Write configuration only while the block is
// idle.
module particle_table_update_core #(
  parameter int MAX_PARTICLES = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  ptu_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output ptu_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [23:0]   cfg_data
);

  logic          gravity_on;
  logic [23:0]   gravity_accel;
  logic [23:0]   drag_rate;
  logic [6:0]    particle_limit;
  logic          accept;
  ptu_pkg::cmd_t cmd;
  ptu_pkg::sts_t sts;

  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      gravity_on     <= 1'b0;
      gravity_accel  <= '0;
      drag_rate      <= '0;
      particle_limit <= 7'd64;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ptu_pkg::CFG_GRAVITY_ON:    gravity_on     <= cfg_data[0];
        ptu_pkg::CFG_GRAVITY_ACCEL: gravity_accel  <= cfg_data;
        ptu_pkg::CFG_DRAG_RATE:     drag_rate      <= cfg_data;
        ptu_pkg::CFG_LIMIT:         particle_limit <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  ptu_ctrl #(.MAX_PARTICLES(MAX_PARTICLES)) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .action         (in_data.action),
    .particle_limit (particle_limit),
    .out_stall      (out_stall),
    .sts            (sts),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .cmd            (cmd)
  );

  ptu_dpath #(.MAX_PARTICLES(MAX_PARTICLES)) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .in_data       (in_data),
    .gravity_on    (gravity_on),
    .gravity_accel (gravity_accel),
    .drag_rate     (drag_rate),
    .cmd           (cmd),
    .sts           (sts),
    .out_data      (out_data)
  );

endmodule
